// File: hdl/dnd_pkg.sv
// dnd_pkg: shared constants and codes for the dns name decompressor
// no dependencies; used by the channel interfaces, the decompressor and the bench

package dnd_pkg;

  // default sizing, handed to the top level parameters
  localparam int PACKET_BYTES_DEF = 512;
  localparam int NAME_MAX_DEF     = 255;
  localparam int MAX_HOPS_DEF     = 8;

  // walk position holds a 14-bit pointer target plus one for the overrun check
  localparam int POS_W = 15;

  // field widths of the channels
  localparam int ADDR_W  = 9;
  localparam int BYTE_W  = 8;
  localparam int VALID_W = 3;
  localparam int CONS_W  = 9;
  localparam int ERR_W   = 2;

  // label and pointer decoding
  localparam logic [7:0] PTR_MARK = 8'hC0;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // action codes of an input transaction
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // error codes of the last result
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_HOPS    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd3;

endpackage

// File: hdl/dnd_in_if.sv
// dnd_in_if: input channel, packet byte writes and decode requests
// depends on dnd_pkg for field widths

interface dnd_in_if;
  import dnd_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output action, output address, output data, input ready);
  modport sink   (input valid, input action, input address, input data, output ready);
endinterface

// File: hdl/dnd_out_if.sv
// dnd_out_if: result channel, up to four name characters per transaction
// depends on dnd_pkg for field widths

interface dnd_out_if;
  import dnd_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  char_a;
  logic [BYTE_W-1:0]  char_b;
  logic [BYTE_W-1:0]  char_c;
  logic [BYTE_W-1:0]  char_d;
  logic [VALID_W-1:0] valid_chars;
  logic               last;
  logic [CONS_W-1:0]  consumed_len;
  logic [ERR_W-1:0]   error;

  modport source (output valid, output char_a, output char_b, output char_c, output char_d,
                  output valid_chars, output last, output consumed_len, output error,
                  input ready);
  modport sink   (input valid, input char_a, input char_b, input char_c, input char_d,
                  input valid_chars, input last, input consumed_len, input error,
                  output ready);
endinterface

// File: hdl/dnd_ram.sv
// dnd_ram: generic single write port, single read port memory
// registered read with read enable; no dependencies

module dnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/dns_name_decompressor.sv
// dns_name_decompressor: packet byte store and dns name walker
// depends on dnd_pkg, dnd_in_if, dnd_out_if and dnd_ram
//
//   channel | direction | transaction
//   --------+-----------+------------------------------------------------
//   cmd     | in        | byte write (action 0) or decode request (action 1)
//   res     | out       | up to four name characters, last marks the end
//
// a decode walks the store through the single read port: each label has its
// length byte fetched and decoded, a dot before it if it is not the first,
// each character read and appended, and an end check; a pointer is fetched,
// decoded and followed; the terminator is decoded before the final result.
// cmd is taken only between walks. reset is synchronous and clears control
// state only; the byte store is not cleared. a full chunk waiting on res
// holds the walk until the result register drains.

module dns_name_decompressor #(
  parameter int PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF,
  parameter int NAME_MAX     = dnd_pkg::NAME_MAX_DEF,
  parameter int MAX_HOPS     = dnd_pkg::MAX_HOPS_DEF
) (
  input logic      clk,
  input logic      rst,
  dnd_in_if.sink   cmd,
  dnd_out_if.source res
);
  import dnd_pkg::*;

  localparam int AW = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] PKT_LIM  = POS_W'(PACKET_BYTES);
  localparam logic [7:0]       NAME_LIM = 8'(NAME_MAX);
  localparam logic [3:0]       HOP_LIM  = 4'(MAX_HOPS);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_LEN, S_PTR, S_DOT, S_LABEL, S_CHAR, S_FINISH
  } state_t;

  state_t             state;
  logic [POS_W-1:0]   pos;
  logic [5:0]         lab_rem;
  logic [3:0]         hops;
  logic [7:0]         name_len;
  logic [CONS_W-1:0]  in_place;
  logic [31:0]        chunk;
  logic [2:0]         pending;
  logic               first;
  logic [5:0]         ptr_hi;
  logic [ERR_W-1:0]   err;

  logic               res_valid;
  logic [31:0]        res_chars;
  logic [VALID_W-1:0] res_count;
  logic               res_last;
  logic [CONS_W-1:0]  res_cons;
  logic [ERR_W-1:0]   res_err;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;

  logic [POS_W-1:0]   cmd_pos;
  logic [POS_W-1:0]   pos_inc;
  logic [POS_W-1:0]   ptr_off;
  logic               out_free;
  logic               res_load;
  logic [7:0]         cur_char;
  logic [31:0]        chunk_ins;

  assign cmd_pos  = POS_W'(cmd.address);
  assign pos_inc  = pos + POS_W'(1);
  assign ptr_off  = POS_W'({ptr_hi, ram_rdata});
  assign out_free = !res_valid || res.ready;
  assign cur_char = (state == S_DOT) ? DOT_CHAR : ram_rdata;

  // result register loads a full chunk or the final one
  assign res_load = out_free && ((state == S_FINISH) ||
                    (((state == S_DOT) || (state == S_CHAR)) &&
                     (name_len < NAME_LIM) && (pending == 3'd4)));

  // place the new character above the ones already pending
  always_comb begin
    unique case (pending[1:0])
      2'd0:    chunk_ins = chunk | {24'd0, cur_char};
      2'd1:    chunk_ins = chunk | {16'd0, cur_char, 8'd0};
      2'd2:    chunk_ins = chunk | {8'd0, cur_char, 16'd0};
      default: chunk_ins = chunk | {cur_char, 24'd0};
    endcase
  end

  // store write port, byte writes from cmd
  assign cmd.ready = (state == S_IDLE);
  assign ram_we    = cmd.valid && cmd.ready && (cmd.action == ACT_WRITE) && (cmd_pos < PKT_LIM);
  assign ram_waddr = cmd_pos[AW-1:0];

  // store read port, driven by the walk
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = pos[AW-1:0];
    unique case (state)
      S_FETCH: ram_re = (pos < PKT_LIM);
      S_LEN: begin
        ram_raddr = pos_inc[AW-1:0];
        ram_re    = ((ram_rdata & PTR_MARK) == PTR_MARK) && (pos_inc < PKT_LIM);
      end
      S_LABEL: ram_re = (lab_rem != 6'd0) && (pos < PKT_LIM);
      default: ram_re = 1'b0;
    endcase
  end

  dnd_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // walk state machine and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      pos       <= '0;
      lab_rem   <= '0;
      hops      <= '0;
      name_len  <= '0;
      in_place  <= '0;
      chunk     <= '0;
      pending   <= '0;
      first     <= 1'b1;
      err       <= ERR_NONE;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        // take a write or start a decode
        S_IDLE: begin
          if (cmd.valid && (cmd.action == ACT_DECODE)) begin
            pos      <= cmd_pos;
            lab_rem  <= '0;
            hops     <= '0;
            name_len <= '0;
            in_place <= '0;
            chunk    <= '0;
            pending  <= '0;
            first    <= 1'b1;
            err      <= ERR_NONE;
            state    <= S_FETCH;
          end
        end

        // read the next length byte
        S_FETCH: begin
          if (pos >= PKT_LIM) begin
            err   <= ERR_RANGE;
            state <= S_FINISH;
          end else begin
            state <= S_LEN;
          end
        end

        // decode terminator, pointer or label length
        S_LEN: begin
          priority if (ram_rdata == 8'd0) begin
            if (hops == 4'd0) in_place <= in_place + CONS_W'(1);
            state <= S_FINISH;
          end else if ((ram_rdata & PTR_MARK) == PTR_MARK) begin
            ptr_hi <= ram_rdata[5:0];
            if (pos_inc >= PKT_LIM) begin
              err   <= ERR_RANGE;
              state <= S_FINISH;
            end else begin
              state <= S_PTR;
            end
          end else begin
            lab_rem <= ram_rdata[5:0];
            if (hops == 4'd0) in_place <= in_place + CONS_W'(1);
            pos   <= pos_inc;
            first <= 1'b0;
            state <= first ? S_LABEL : S_DOT;
          end
        end

        // follow a compression pointer
        S_PTR: begin
          if (hops == 4'd0) in_place <= in_place + CONS_W'(2);
          if (hops >= HOP_LIM) begin
            err   <= ERR_HOPS;
            state <= S_FINISH;
          end else begin
            hops <= hops + 4'd1;
            if (ptr_off >= PKT_LIM) begin
              err   <= ERR_RANGE;
              state <= S_FINISH;
            end else begin
              pos   <= ptr_off;
              state <= S_FETCH;
            end
          end
        end

        // next label character, or back to the length byte
        S_LABEL: begin
          if (lab_rem == 6'd0) begin
            state <= S_FETCH;
          end else if (pos >= PKT_LIM) begin
            err   <= ERR_RANGE;
            state <= S_FINISH;
          end else begin
            state <= S_CHAR;
          end
        end

        // append a dot or a label character, sending a full chunk first
        S_DOT, S_CHAR: begin
          if (name_len >= NAME_LIM) begin
            err   <= ERR_TOO_LONG;
            state <= S_FINISH;
          end else if (!((pending == 3'd4) && !out_free)) begin
            if (pending == 3'd4) begin
              res_chars <= chunk;
              res_count <= VALID_W'(4);
              res_last  <= 1'b0;
              res_cons  <= '0;
              res_err   <= ERR_NONE;
              chunk     <= {24'd0, cur_char};
              pending   <= 3'd1;
            end else begin
              chunk   <= chunk_ins;
              pending <= pending + 3'd1;
            end
            name_len <= name_len + 8'd1;
            if (state == S_CHAR) begin
              if (hops == 4'd0) in_place <= in_place + CONS_W'(1);
              pos     <= pos_inc;
              lab_rem <= lab_rem - 6'd1;
            end
            state <= S_LABEL;
          end
        end

        // send the final chunk
        S_FINISH: begin
          if (out_free) begin
            res_chars <= chunk;
            res_count <= VALID_W'(pending);
            res_last  <= 1'b1;
            res_cons  <= (err != ERR_NONE) ? '0 : in_place;
            res_err   <= err;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid        = res_valid;
  assign res.char_a       = res_chars[7:0];
  assign res.char_b       = res_chars[15:8];
  assign res.char_c       = res_chars[23:16];
  assign res.char_d       = res_chars[31:24];
  assign res.valid_chars  = res_count;
  assign res.last         = res_last;
  assign res.consumed_len = res_cons;
  assign res.error        = res_err;

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for the dns name decompressor
// needs dnd_pkg, dnd_in_if, dnd_out_if and the dns_name_decompressor rtl

`timescale 1ns / 1ps

module tb_top;
  import dnd_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RAND_ITEMS   = 26;
  localparam int RAND_DECODES = 4;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int CHUNK_CAP    = 64;
  localparam int RAND_BASE    = 80;
  localparam int RAND_END     = 500;

  typedef struct {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0][BYTE_W-1:0] chars;
    logic [VALID_W-1:0]     nvalid;
    logic                   is_last;
    logic [CONS_W-1:0]      consumed;
    logic [ERR_W-1:0]       code;
  } chunk_t;

  logic clk = 1'b0;
  logic rst;

  dnd_in_if  cmd_ch ();
  dnd_out_if res_ch ();

  dns_name_decompressor uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // pending commands, expected name chunks, mirror of the packet store
  cmd_item_t   cmd_backlog [$];
  chunk_t      name_chunks_q [$];
  logic [7:0]  mirror_bytes [0:PACKET_BYTES_DEF-1];

  // walker state of the predictor
  logic [31:0] w_buf;
  int unsigned w_pend;
  int unsigned w_len;
  int unsigned w_count;

  int  queued_items   = 0;
  int  queued_decodes = 0;
  int  accepted_items = 0;
  int  seen_writes    = 0;
  int  seen_decodes   = 0;
  int  seen_chunks    = 0;
  int  fail_count     = 0;
  int  cycle_count    = 0;
  int  hold_mark      = 0;
  int  outcome_seen [4] = '{0, 0, 0, 0};
  int  cmd_gap        = 0;
  int  rdy_gap        = 0;
  bit  cmd_took       = 1'b0;
  bit  hold_on        = 1'b0;
  bit  calm           = 1'b0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // reset once at the start, inputs known from time zero
  initial begin
    rst = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.action  = ACT_WRITE;
    cmd_ch.address = '0;
    cmd_ch.data    = '0;
    res_ch.ready   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fail_count++;
    $display("mismatch at chunk %0d: %s got %0h expected %0h", seen_chunks, what, got, want);
  endtask

  function automatic void close_chunk(input int unsigned nv, input logic lst,
                                      input int unsigned cons, input logic [ERR_W-1:0] code);
    chunk_t c;
    if (w_count >= CHUNK_CAP) return;
    for (int k = 0; k < 4; k++)
      c.chars[k] = (k < nv) ? w_buf[8*k +: 8] : 8'h00;
    c.nvalid   = nv[VALID_W-1:0];
    c.is_last  = lst;
    c.consumed = cons[CONS_W-1:0];
    c.code     = code;
    name_chunks_q.push_back(c);
    w_count++;
  endfunction

  // add one character to the name, flushing a full chunk first
  function automatic logic [ERR_W-1:0] append_char(input logic [BYTE_W-1:0] ch);
    if (w_len >= NAME_MAX_DEF) return ERR_TOO_LONG;
    if (w_pend == 4) begin
      close_chunk(4, 1'b0, 0, ERR_NONE);
      w_buf  = '0;
      w_pend = 0;
    end
    w_buf[8*w_pend +: 8] = ch;
    w_pend++;
    w_len++;
    return ERR_NONE;
  endfunction

  // walk labels and pointers from start, queue the expected chunks
  function automatic void walk_name(input logic [ADDR_W-1:0] start);
    int unsigned      pos;
    int unsigned      hops;
    int unsigned      inplace;
    int unsigned      remain;
    int unsigned      tgt;
    logic [7:0]       b;
    logic [ERR_W-1:0] code;
    bit               first;
    pos     = start;
    hops    = 0;
    inplace = 0;
    code    = ERR_NONE;
    first   = 1'b1;
    w_buf   = '0;
    w_pend  = 0;
    w_len   = 0;
    w_count = 0;
    while (1'b1) begin
      if (pos >= PACKET_BYTES_DEF) begin
        code = ERR_RANGE;
        break;
      end
      b = mirror_bytes[pos];
      if (b == 8'h00) begin
        if (hops == 0) inplace++;
        break;
      end
      // compression pointer
      if ((b & PTR_MARK) == PTR_MARK) begin
        if (pos + 1 >= PACKET_BYTES_DEF) begin
          code = ERR_RANGE;
          break;
        end
        tgt = {b[5:0], mirror_bytes[pos+1]};
        if (hops == 0) inplace += 2;
        if (hops >= MAX_HOPS_DEF) begin
          code = ERR_HOPS;
          break;
        end
        hops++;
        if (tgt >= PACKET_BYTES_DEF) begin
          code = ERR_RANGE;
          break;
        end
        pos = tgt;
        continue;
      end
      // label, reserved top bits taken as a plain length
      remain = b[5:0];
      if (hops == 0) inplace++;
      pos++;
      if (!first) begin
        code = append_char(DOT_CHAR);
        if (code != ERR_NONE) break;
      end
      first = 1'b0;
      while (remain > 0) begin
        if (pos >= PACKET_BYTES_DEF) begin
          code = ERR_RANGE;
          break;
        end
        code = append_char(mirror_bytes[pos]);
        if (code != ERR_NONE) break;
        if (hops == 0) inplace++;
        pos++;
        remain--;
      end
      if (code != ERR_NONE) break;
    end
    close_chunk(w_pend, 1'b1, (code != ERR_NONE) ? 0 : inplace, code);
  endfunction

  function automatic void queue_write(input int a, input int v);
    cmd_item_t it;
    it.action  = ACT_WRITE;
    it.address = a[ADDR_W-1:0];
    it.data    = v[BYTE_W-1:0];
    cmd_backlog.push_back(it);
    queued_items++;
  endfunction

  function automatic void queue_decode(input int a);
    cmd_item_t it;
    it.action  = ACT_DECODE;
    it.address = a[ADDR_W-1:0];
    it.data    = $urandom_range(0, 255);
    cmd_backlog.push_back(it);
    queued_items++;
    queued_decodes++;
  endfunction

  // write a label with given text, return the byte after it
  function automatic int put_label(input int at, input string s);
    queue_write(at, s.len());
    for (int i = 0; i < s.len(); i++)
      queue_write(at + 1 + i, s[i]);
    return at + 1 + s.len();
  endfunction

  // write a length byte and len random characters, return the byte after them
  function automatic int put_random_label(input int at, input int hdr, input int len);
    queue_write(at, hdr);
    for (int i = 1; i <= len; i++)
      queue_write(at + i, $urandom_range(0, 255));
    return at + 1 + len;
  endfunction

  // command side: accept, mirror writes, predict decodes
  always @(posedge clk) begin
    cmd_took <= !rst && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1;
    if (!rst && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
      accepted_items++;
      if (cmd_ch.action == ACT_WRITE) begin
        seen_writes++;
        if (cmd_ch.address < PACKET_BYTES_DEF)
          mirror_bytes[cmd_ch.address] = cmd_ch.data;
      end else begin
        seen_decodes++;
        walk_name(cmd_ch.address);
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    cmd_item_t it;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !cmd_took) begin
      // transaction still on offer
    end else if (cmd_gap > 0) begin
      cmd_gap <= cmd_gap - 1;
      cmd_ch.valid <= 1'b0;
    end else if (cmd_backlog.size() > 0) begin
      it = cmd_backlog.pop_front();
      cmd_ch.action  <= it.action;
      cmd_ch.address <= it.address;
      cmd_ch.data    <= it.data;
      cmd_ch.valid   <= 1'b1;
      cmd_gap <= pick_gap();
    end else begin
      cmd_ch.valid <= 1'b0;
    end
  end

  // result ready with random stalls, forced low during the long hold
  always @(negedge clk) begin
    if (rst || hold_on) begin
      res_ch.ready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap <= rdy_gap - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      rdy_gap <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    chunk_t                 want;
    logic [3:0][BYTE_W-1:0] got;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (name_chunks_q.size() == 0) begin
        note_mismatch("transaction with nothing expected", 0, 0);
      end else begin
        want = name_chunks_q.pop_front();
        got  = {res_ch.char_d, res_ch.char_c, res_ch.char_b, res_ch.char_a};
        for (int k = 0; k < 4; k++)
          if (got[k] !== want.chars[k])
            note_mismatch($sformatf("char_%c", 8'h61 + k), got[k], want.chars[k]);
        if (res_ch.valid_chars !== want.nvalid)
          note_mismatch("valid_chars", res_ch.valid_chars, want.nvalid);
        if (res_ch.last !== want.is_last)
          note_mismatch("last", res_ch.last, want.is_last);
        if (res_ch.consumed_len !== want.consumed)
          note_mismatch("consumed_len", res_ch.consumed_len, want.consumed);
        if (res_ch.error !== want.code)
          note_mismatch("error", res_ch.error, want.code);
        if (want.is_last) outcome_seen[want.code]++;
      end
      seen_chunks++;
    end
  end

  // long receiver hold while commands keep coming
  initial begin
    wait (hold_mark != 0 && accepted_items >= hold_mark);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_on = 1'b0;
  end

  // alternate stretches with and without idling
  initial begin
    forever begin
      calm = 1'b0;
      repeat ($urandom_range(200, 600)) @(posedge clk);
      calm = 1'b1;
      repeat ($urandom_range(100, 300)) @(posedge clk);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int p;
    int base;
    int nlab;
    int llen;
    int hdr;
    int kind;
    int tgt;
    int rp;
    int rand_start;
    int dec_start;
    int name_starts [$];

    // crafted names, only the bytes that the walks read are written
    queue_write(0, 8'h00);                              // root name
    p = put_label(1, "www");
    p = put_label(p, "ex");
    p = put_label(p, "com");
    queue_write(p, 8'h00);
    p = put_label(13, "mail");                          // label then pointer
    queue_write(p, PTR_MARK);
    queue_write(p + 1, 5);
    p = put_label(20, "a");                             // empty and reserved labels
    queue_write(22, 8'h40);
    queue_write(23, 8'h82);
    queue_write(24, "b");
    queue_write(25, "c");
    queue_write(26, 8'h00);
    queue_write(27, PTR_MARK);                          // pointer to itself
    queue_write(28, 27);
    p = put_label(29, "q");                             // pointer target past the store
    queue_write(31, PTR_MARK | 8'h02);
    queue_write(32, 8'h00);
    p = put_label(33, "abcd");                          // exactly one full chunk
    queue_write(p, 8'h00);
    queue_write(39, 3);                                 // extreme character values
    queue_write(40, 8'hFF);
    queue_write(41, 8'h00);
    queue_write(42, 8'h80);
    queue_write(43, 8'h00);
    queue_write(44, 8'hFF);                             // largest pointer target
    queue_write(45, 8'hFF);
    p = put_random_label(46, 30, 30);                   // label looping until too long
    queue_write(p, PTR_MARK);
    queue_write(p + 1, 46);
    p = put_random_label(505, 8'h0F, 5);                // label running off the store
    queue_write(511, PTR_MARK);                         // pointer missing its second byte

    queue_decode(0);
    queue_decode(1);
    queue_decode(13);
    queue_decode(20);
    queue_decode(27);
    queue_decode(29);
    queue_decode(33);
    queue_decode(39);
    queue_decode(44);
    queue_decode(46);
    queue_decode(505);
    queue_decode(511);
    hold_mark = queued_items - 8;

    // random part: fresh names in an unused area, pointers to known names or past the store
    name_starts.push_back(1);
    name_starts.push_back(13);
    name_starts.push_back(33);
    rp         = RAND_BASE;
    rand_start = queued_items;
    dec_start  = queued_decodes;
    while (queued_items - rand_start < RAND_ITEMS || queued_decodes - dec_start < RAND_DECODES)
    begin
      kind = $urandom_range(0, 99);
      if (kind < 60 && rp + 24 < RAND_END) begin
        base = rp;
        p    = rp;
        nlab = $urandom_range(1, 3);
        for (int i = 0; i < nlab; i++) begin
          llen = $urandom_range(0, 6);
          hdr  = llen;
          if (llen == 0 || $urandom_range(0, 9) == 0) hdr = hdr | ($urandom_range(1, 2) << 6);
          p = put_random_label(p, hdr, llen);
        end
        if ($urandom_range(0, 3) == 0) begin
          tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
          queue_write(p, PTR_MARK | (tgt >> 8));
          queue_write(p + 1, tgt & 8'hFF);
          rp = p + 2;
        end else begin
          queue_write(p, 0);
          rp = p + 1;
        end
        name_starts.push_back(base);
        queue_decode(base);
      end else if (kind < 85) begin
        queue_decode(name_starts[$urandom_range(0, name_starts.size() - 1)]);
      end else if (rp + 2 < RAND_END) begin
        tgt = $urandom_range(PACKET_BYTES_DEF, 16383);
        queue_write(rp, PTR_MARK | (tgt >> 8));
        queue_write(rp + 1, tgt & 8'hFF);
        queue_decode(rp);
        rp = rp + 2;
      end else begin
        queue_decode(name_starts[0]);
      end
    end

    // wait for every transaction and every expected chunk, then drain
    while (!(accepted_items == queued_items && name_chunks_q.size() == 0)) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d byte writes and %0d name decodes, %0d result chunks checked",
             seen_writes, seen_decodes, seen_chunks);
    $display("decode outcomes: %0d clean, %0d out of store, %0d hop limit, %0d too long",
             outcome_seen[ERR_NONE], outcome_seen[ERR_RANGE], outcome_seen[ERR_HOPS],
             outcome_seen[ERR_TOO_LONG]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
